FILE: rtl/core/tta_pkg.sv
// ----------------------------------------------------------------------------
// tta_pkg: shared types and helpers for the transpose address generator
// Register codes, config/control structs and the size and rank clamps.
// ----------------------------------------------------------------------------
package tta_pkg;

    // Fixed geometry of the walk
    localparam int AXES       = 4;
    localparam int CELL_W     = 2;
    localparam int RANK_W     = 3;
    localparam int SIZE_W     = 9;
    localparam int CNT_W      = 8;
    localparam int PERM_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_W      = 32;

    // Parameter defaults
    localparam int DEF_MAX_RANK   = 4;
    localparam int DEF_INDEX_BITS = 32;

    // Register reset values
    localparam logic [RANK_W-1:0]      RANK_RESET = 3'd4;
    localparam logic [SIZE_W-1:0]      SIZE_RESET = 9'd1;
    localparam logic [AXES*PERM_W-1:0] PERM_RESET = 8'd228;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK,
        REG_DIM0,
        REG_DIM1,
        REG_DIM2,
        REG_DIM3,
        REG_PERM
    } cfg_reg_t;

    // Configuration as seen by the derive sequencer
    typedef struct packed {
        logic [RANK_W-1:0]            rank;
        logic [AXES-1:0][SIZE_W-1:0]  dim_size;
        logic [AXES-1:0][PERM_W-1:0]  perm;
    } tta_cfg_t;

    // Per-cell load strobe from the derive sequencer
    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] idx;
        logic [CNT_W-1:0]  bm1;
    } tta_load_t;

    // Size 0 reads as 1, anything above 256 saturates
    function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] s;
        s = v;
        if (v == '0)
        begin
            s = 9'd1;
        end
        else if (v > 9'd256)
        begin
            s = 9'd256;
        end
        return s;
    endfunction

    // Rank 0 reads as 1, above the cell count saturates
    function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] rank,
                                                   input logic [RANK_W-1:0] lim);
        logic [RANK_W-1:0] r;
        r = rank;
        if (r == '0)
        begin
            r = 3'd1;
        end
        if (r > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/tta_cell.sv
// ----------------------------------------------------------------------------
// tta_cell: one output axis of the transpose walk
// Holds the axis counter, its wrap point and its source step. Takes the
// carry from the next inner axis and hands carry and step to the outer one.
// ----------------------------------------------------------------------------
module tta_cell
    import tta_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int CELL_ID    = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tta_load_t             load,
    input  logic [INDEX_BITS-1:0] step,
    input  logic                  clear,
    input  logic                  advance,
    input  logic                  restart,
    input  logic                  carry_in,
    input  logic [INDEX_BITS-1:0] delta_in,
    output logic                  carry_out,
    output logic [INDEX_BITS-1:0] delta_out
);

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [CNT_W-1:0]      bm1_reg;
    logic [INDEX_BITS-1:0] step_reg;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  at_max;
    logic                  incr;

    // Counter as seen by this beat (restart reads as zero)
    assign cnt_eff   = restart ? '0 : cnt_reg;
    assign at_max    = (cnt_eff == bm1_reg);
    assign incr      = carry_in && !at_max;
    assign carry_out = carry_in && at_max;
    assign delta_out = incr ? step_reg : delta_in;

    // Next counter: clear on a register write, else bump, wrap on carry or hold
    always_comb
    begin
        cnt_next = cnt_reg;
        if (clear)
        begin
            cnt_next = '0;
        end
        else if (advance)
        begin
            if (incr)
            begin
                cnt_next = cnt_eff + 8'd1;
            end
            else if (carry_in)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Bound and step loaded by the derive sequencer
    always_ff @(posedge clk)
    begin
        if (load.valid && (load.idx == CELL_W'(CELL_ID)))
        begin
            bm1_reg  <= load.bm1;
            step_reg <= step;
        end
    end

endmodule

FILE: rtl/core/tta_derive.sv
// ----------------------------------------------------------------------------
// tta_derive: stride and step sequencer
// Builds row-major strides with one shared multiplier, then per output axis
// its wrap point, its span and its source step, loading one cell at a time.
// ----------------------------------------------------------------------------
module tta_derive
    import tta_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int NUM_CELLS  = DEF_MAX_RANK
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tta_cfg_t              cfg,
    input  logic                  start,
    output logic                  busy,
    output tta_load_t             load,
    output logic [INDEX_BITS-1:0] step
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STRIDE,
        S_SPAN,
        S_ACC
    } state_t;

    localparam int MUL_W = INDEX_BITS + SIZE_W;

    state_t                state_reg;
    logic [CELL_W-1:0]     i_reg;
    logic [CELL_W-1:0]     k_reg;
    logic [INDEX_BITS-1:0] st_reg [AXES-1];
    logic [INDEX_BITS-1:0] prod_reg;
    logic [INDEX_BITS-1:0] acc_reg;

    logic [RANK_W-1:0]     r;
    logic [PERM_W-1:0]     p;
    logic                  map_ok;
    logic [CELL_W-1:0]     rd_addr;
    logic [INDEX_BITS-1:0] st_rd;
    logic [SIZE_W-1:0]     size_p;
    logic [SIZE_W-1:0]     size_i;
    logic [INDEX_BITS-1:0] stride_k;
    logic [CNT_W-1:0]      bm1_k;
    logic [INDEX_BITS-1:0] mul_a;
    logic [SIZE_W-1:0]     mul_b;
    logic [MUL_W-1:0]      mul_full;
    logic [INDEX_BITS-1:0] mul_lo;

    // Axis mapping for the cell under work
    assign r       = eff_rank(cfg.rank, RANK_W'(NUM_CELLS));
    assign p       = cfg.perm[k_reg];
    assign map_ok  = ({1'b0, k_reg} < r) && ({1'b0, p} < r);
    assign rd_addr = (state_reg == S_STRIDE) ? i_reg : p;
    assign st_rd   = (rd_addr == CELL_W'(AXES-1)) ? INDEX_BITS'(1) : st_reg[rd_addr];
    assign size_p  = size_clamp(cfg.dim_size[p]);
    assign size_i  = size_clamp(cfg.dim_size[i_reg]);
    assign stride_k = map_ok ? st_rd : '0;
    assign bm1_k    = map_ok ? CNT_W'(size_p - 9'd1) : '0;

    // Shared multiplier: strides first, then spans
    always_comb
    begin
        if (state_reg == S_STRIDE)
        begin
            mul_a = st_rd;
            mul_b = ({1'b0, i_reg} < r) ? size_i : 9'd1;
        end
        else
        begin
            mul_a = stride_k;
            mul_b = {1'b0, bm1_k};
        end
    end

    assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign mul_lo   = mul_full[INDEX_BITS-1:0];

    // Step = own stride minus the spans of all inner axes
    assign busy       = (state_reg != S_IDLE);
    assign load.valid = (state_reg == S_SPAN);
    assign load.idx   = k_reg;
    assign load.bm1   = bm1_k;
    assign step       = stride_k - acc_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_STRIDE;
            i_reg     <= CELL_W'(AXES-1);
            k_reg     <= CELL_W'(NUM_CELLS-1);
            prod_reg  <= '0;
            acc_reg   <= '0;
            for (int j = 0; j < AXES-1; j++)
            begin
                st_reg[j] <= '0;
            end
        end
        else if (start)
        begin
            state_reg <= S_STRIDE;
            i_reg     <= CELL_W'(AXES-1);
        end
        else
        begin
            case (state_reg)
                S_STRIDE:
                begin
                    st_reg[i_reg - CELL_W'(1)] <= mul_lo;
                    if (i_reg == CELL_W'(1))
                    begin
                        state_reg <= S_SPAN;
                        k_reg     <= CELL_W'(NUM_CELLS-1);
                        acc_reg   <= '0;
                    end
                    else
                    begin
                        i_reg <= i_reg - CELL_W'(1);
                    end
                end
                S_SPAN:
                begin
                    prod_reg  <= mul_lo;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_reg + prod_reg;
                    if (k_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg - CELL_W'(1);
                        state_reg <= S_SPAN;
                    end
                end
                S_IDLE:
                begin
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/tensor_transpose_address_gen.sv
// ----------------------------------------------------------------------------
// tensor_transpose_address_gen: N-d transpose gather address generator
// Results are registered into the output stage, or into the skid stage while
//   the output holds a stalled result. Throughput: one beat per cycle while
//   the sequencer is idle, the skid is empty and no register is written.
// After reset and after each write to a listed register the stride sequencer
//   runs its stride, span and accumulate steps with the input stalled.
// Reset loads the register defaults and clears the walk and the valid flags.
// ----------------------------------------------------------------------------
module tensor_transpose_address_gen
    import tta_pkg::*;
#(
    parameter int MAX_RANK   = DEF_MAX_RANK,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      source_index,
    output logic [OUT_W-1:0]      dest_index,
    output logic                  last
);

    localparam int CELLS = (MAX_RANK < AXES) ? MAX_RANK : AXES;

    tta_cfg_t              cfg_reg;
    logic                  cfg_hit;
    logic                  cfg_start;
    logic                  busy;
    tta_load_t             load;
    logic [INDEX_BITS-1:0] step;

    logic [CELLS:0]        carry;
    logic [INDEX_BITS-1:0] delta [CELLS+1];

    logic [INDEX_BITS-1:0] src_reg;
    logic [INDEX_BITS-1:0] dst_reg;
    logic [INDEX_BITS-1:0] src_eff;
    logic [INDEX_BITS-1:0] dst_eff;
    logic                  accept;
    logic                  out_take;
    logic                  walk_last;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_src_reg;
    logic [OUT_W-1:0]      out_dst_reg;
    logic                  out_last_reg;
    logic                  skid_valid_reg;
    logic [OUT_W-1:0]      skid_src_reg;
    logic [OUT_W-1:0]      skid_dst_reg;
    logic                  skid_last_reg;

    // Register decode; writes past the list are dropped
    always_comb
    begin
        case (cfg_index)
            REG_RANK, REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3, REG_PERM: cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
        endcase
    end

    assign cfg_start = cfg_we && cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rank     <= RANK_RESET;
            cfg_reg.dim_size <= {AXES{SIZE_RESET}};
            cfg_reg.perm     <= PERM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANK: cfg_reg.rank        <= cfg_data[RANK_W-1:0];
                REG_DIM0: cfg_reg.dim_size[0] <= cfg_data;
                REG_DIM1: cfg_reg.dim_size[1] <= cfg_data;
                REG_DIM2: cfg_reg.dim_size[2] <= cfg_data;
                REG_DIM3: cfg_reg.dim_size[3] <= cfg_data;
                REG_PERM: cfg_reg.perm        <= cfg_data[AXES*PERM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stride sequencer
    tta_derive #(
        .INDEX_BITS (INDEX_BITS),
        .NUM_CELLS  (CELLS)
    ) u_derive (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .start (cfg_start),
        .busy  (busy),
        .load  (load),
        .step  (step)
    );

    // Handshake
    assign in_stall = busy || skid_valid_reg || cfg_we;
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // Axis chain, innermost cell last; carry enters from the inside
    assign carry[CELLS] = 1'b1;
    assign delta[CELLS] = '0;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        tta_cell #(
            .INDEX_BITS (INDEX_BITS),
            .CELL_ID    (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .step      (step),
            .clear     (cfg_start),
            .advance   (accept),
            .restart   (restart),
            .carry_in  (carry[k+1]),
            .delta_in  (delta[k+1]),
            .carry_out (carry[k]),
            .delta_out (delta[k])
        );
    end

    assign walk_last = carry[0];
    assign src_eff   = restart ? '0 : src_reg;
    assign dst_eff   = restart ? '0 : dst_reg;

    // Running indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            dst_reg <= '0;
        end
        else if (cfg_start)
        begin
            src_reg <= '0;
            dst_reg <= '0;
        end
        else if (accept)
        begin
            if (walk_last)
            begin
                src_reg <= '0;
                dst_reg <= '0;
            end
            else
            begin
                src_reg <= src_eff + delta[0];
                dst_reg <= dst_eff + INDEX_BITS'(1);
            end
        end
    end

    // Output register and skid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_src_reg  <= skid_src_reg;
                out_dst_reg  <= skid_dst_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_src_reg  <= OUT_W'(src_eff);
                skid_dst_reg  <= OUT_W'(dst_eff);
                skid_last_reg <= walk_last;
            end
            else
            begin
                out_src_reg  <= OUT_W'(src_eff);
                out_dst_reg  <= OUT_W'(dst_eff);
                out_last_reg <= walk_last;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = out_src_reg;
    assign dest_index   = out_dst_reg;
    assign last         = out_last_reg;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled output");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && walk_last) |=> (dst_reg == '0 && src_reg == '0))
        else $error("walk did not wrap after the final element");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_start |=> in_stall)
        else $error("input opened right after a register write");

endmodule

FILE: bench/tensor_transpose_address_gen_tb.sv
// ----------------------------------------------------------------------------
// tensor_transpose_address_gen_tb: self-checking bench for the transpose walk
// A local copy of the stride and counter walk predicts source index, dest
// index and last for every accepted tick (typed table rows give their own).
// A short table (reset values, register extremes, restart, axes beyond rank)
// is followed by large stride and full 256-element walks, then random register
// settings and ticks; both channels idle at random for the first 260 beats.
// ----------------------------------------------------------------------------
module tensor_transpose_address_gen_tb;
    import tta_pkg::*;

    localparam int RANK_CAP     = (DEF_MAX_RANK < AXES) ? DEF_MAX_RANK : AXES;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BEATS = 80;

    typedef struct packed {
        logic [OUT_W-1:0] src;
        logic [OUT_W-1:0] dst;
        logic             lst;
    } addr_beat_t;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_reg_t          regsel;
        logic [CFG_DATA_W-1:0] value;
        logic              rs;
        bit                typed;
        addr_beat_t        want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  restart;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_W-1:0]      source_index;
    logic [OUT_W-1:0]      dest_index;
    logic                  last;

    // Walk predictor state
    logic [RANK_W-1:0]     cfg_rank;
    logic [SIZE_W-1:0]     cfg_size [AXES];
    logic [7:0]            cfg_perm;
    int unsigned           live_rank;
    int unsigned           axis_bound [AXES];
    logic [OUT_W-1:0]      axis_stride [AXES];
    int unsigned           axis_count [AXES];
    logic [OUT_W-1:0]      src_run;
    logic [OUT_W-1:0]      dst_run;

    addr_beat_t            pending_beats [$];
    bit                    typed_now;
    addr_beat_t            typed_beat;
    int unsigned           beats_sent;
    int unsigned           fail_count;
    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;

    // Directed stimulus: writes and ticks in order
    row_t script [38] = '{
        // reset config: one-element walk, every tick is last
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b1, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b1, '{32'd0, 32'd0, 1'b1}},
        // 2x3x4 with a rotating permutation
        '{ROW_WRITE, REG_RANK, 9'd3,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM0, 9'd2,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM1, 9'd3,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM2, 9'd4,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_PERM, 9'd210, 1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b1, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        // rank saturates, size 511 saturates, size 0, repeated axes
        '{ROW_WRITE, REG_RANK, 9'd7,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM1, 9'd511, 1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM2, 9'd256, 1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM3, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_PERM, 9'h033, 1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        // rank 0 reads as 1, inner axis names an axis beyond rank
        '{ROW_WRITE, REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_PERM, 9'h0E7, 1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        // rank 1 over a 5-element axis
        '{ROW_WRITE, REG_RANK, 9'd1,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_PERM, 9'h0E4, 1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_DIM0, 9'd5,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b1, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{ROW_TICK,  REG_RANK, 9'd0,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}}
    };

    tensor_transpose_address_gen dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .source_index (source_index),
        .dest_index   (dest_index),
        .last         (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Size 0 acts as 1, above 256 acts as 256
    function automatic int unsigned clamped_size(input int unsigned axis);
        int unsigned v;
        v = cfg_size[axis];
        if (v == 0)
        begin
            v = 1;
        end
        else if (v > 256)
        begin
            v = 256;
        end
        return v;
    endfunction

    function automatic void clear_walk();
        for (int k = 0; k < AXES; k++)
        begin
            axis_count[k] = 0;
        end
        src_run = '0;
        dst_run = '0;
    endfunction

    // Row-major strides, then reordered into output axis order
    function automatic void rebuild_strides();
        logic [OUT_W-1:0] row_stride [AXES];
        int unsigned      p;
        live_rank = cfg_rank;
        if (live_rank == 0)
        begin
            live_rank = 1;
        end
        if (live_rank > RANK_CAP)
        begin
            live_rank = RANK_CAP;
        end
        for (int k = 0; k < AXES; k++)
        begin
            row_stride[k] = '0;
        end
        row_stride[live_rank-1] = 1;
        for (int k = live_rank - 1; k > 0; k--)
        begin
            row_stride[k-1] = row_stride[k] * clamped_size(k);
        end
        for (int k = 0; k < AXES; k++)
        begin
            p = cfg_perm[2*k +: 2];
            if (k < live_rank && p < live_rank)
            begin
                axis_bound[k]  = clamped_size(p);
                axis_stride[k] = row_stride[p];
            end
            else
            begin
                axis_bound[k]  = 1;
                axis_stride[k] = '0;
            end
        end
    endfunction

    // Register write: any index in range rebuilds and restarts the walk
    function automatic void note_write(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        case (r)
            REG_RANK: cfg_rank    = v[RANK_W-1:0];
            REG_DIM0: cfg_size[0] = v;
            REG_DIM1: cfg_size[1] = v;
            REG_DIM2: cfg_size[2] = v;
            REG_DIM3: cfg_size[3] = v;
            REG_PERM: cfg_perm    = v[7:0];
            default: return;
        endcase
        rebuild_strides();
        clear_walk();
    endfunction

    // One tick of the walk: current indices out, then step the counters
    function automatic void walk_tick(input logic rs, output addr_beat_t b);
        int unsigned a;
        bit          fin;
        if (rs)
        begin
            clear_walk();
        end
        fin = 1'b1;
        for (int k = 0; k < live_rank; k++)
        begin
            if (axis_count[k] + 1 < axis_bound[k])
            begin
                fin = 1'b0;
            end
        end
        b.src = src_run;
        b.dst = dst_run;
        b.lst = fin;
        if (fin)
        begin
            clear_walk();
            return;
        end
        dst_run = dst_run + 1;
        for (int k = live_rank; k > 0; k--)
        begin
            a = k - 1;
            if (axis_count[a] + 1 < axis_bound[a])
            begin
                axis_count[a]++;
                src_run = src_run + axis_stride[a];
                break;
            end
            src_run = src_run - OUT_W'(axis_count[a]) * axis_stride[a];
            axis_count[a] = 0;
        end
    endfunction

    function automatic longint unsigned walk_length();
        longint unsigned n;
        n = 1;
        for (int k = 0; k < live_rank; k++)
        begin
            n = n * axis_bound[k];
        end
        return n;
    endfunction

    function automatic void flag_field(input string name, input logic [OUT_W-1:0] want,
                                       input logic [OUT_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    endfunction

    // Check result beats against the oldest expectation, then log new ticks
    always @(posedge clk)
    begin : scoreboard
        addr_beat_t exp_beat;
        addr_beat_t nxt_beat;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_beats.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat, expected none actual %h %h %b",
                             $time, source_index, dest_index, last);
                end
                else
                begin
                    exp_beat = pending_beats.pop_front();
                    if (source_index !== exp_beat.src)
                    begin
                        flag_field("source_index", exp_beat.src, source_index);
                    end
                    if (dest_index !== exp_beat.dst)
                    begin
                        flag_field("dest_index", exp_beat.dst, dest_index);
                    end
                    if (last !== exp_beat.lst)
                    begin
                        flag_field("last", OUT_W'(exp_beat.lst), OUT_W'(last));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                walk_tick(restart, nxt_beat);
                if (typed_now)
                begin
                    nxt_beat = typed_beat;
                end
                pending_beats.insert(pending_beats.size(), nxt_beat);
                beats_sent++;
            end
        end
    end

    // Receiver stall
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles with no beat accepted or delivered
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // Idle mix follows progress: sender light, then receiver light, then none
    function automatic void pick_idle_mix();
        if (beats_sent < 130)
        begin
            send_idle_pct = 18;
            recv_idle_pct = 52;
        end
        else if (beats_sent < 260)
        begin
            send_idle_pct = 52;
            recv_idle_pct = 18;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_tick(input logic rs, input bit typed, input addr_beat_t want);
        pick_idle_mix();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        restart    <= rs;
        typed_now  = typed;
        typed_beat = want;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Hold off the sender until every expected beat is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        note_write(r, v);
        @(negedge clk);
    endtask

    task automatic random_setting();
        cfg_reg_t    r;
        int unsigned writes;
        int unsigned pick;
        logic [CFG_DATA_W-1:0] v;
        writes = 0;
        for (int i = 0; i < 6; i++)
        begin
            r = cfg_reg_t'(i);
            if ($urandom_range(0, 3) != 0 || (r == REG_PERM && writes == 0))
            begin
                case (r)
                    REG_RANK: v = CFG_DATA_W'($urandom_range(0, 7));
                    REG_PERM: v = CFG_DATA_W'($urandom_range(0, 255));
                    default:
                    begin
                        // mostly small axes so walks finish; a few edge sizes
                        pick = $urandom_range(0, 19);
                        if (pick < 15)
                        begin
                            v = CFG_DATA_W'($urandom_range(1, 4));
                        end
                        else if (pick == 15)
                        begin
                            v = '0;
                        end
                        else if (pick == 16)
                        begin
                            v = 9'd256;
                        end
                        else if (pick == 17)
                        begin
                            v = CFG_DATA_W'($urandom_range(257, 511));
                        end
                        else
                        begin
                            v = CFG_DATA_W'($urandom_range(5, 9));
                        end
                    end
                endcase
                write_reg(r, v);
                writes++;
            end
        end
        cfg_we <= 1'b0;
    endtask

    // Main stimulus
    initial
    begin : stimulus
        int unsigned       n;
        int unsigned       random_beats;
        longint unsigned   walk;
        bit                in_writes;
        addr_beat_t        blank;
        cfg_rank      = RANK_RESET;
        cfg_perm      = PERM_RESET;
        for (int k = 0; k < AXES; k++)
        begin
            cfg_size[k] = SIZE_RESET;
        end
        rebuild_strides();
        clear_walk();
        blank         = '0;
        typed_now     = 1'b0;
        typed_beat    = '0;
        beats_sent    = 0;
        fail_count    = 0;
        send_idle_pct = 18;
        recv_idle_pct = 52;
        in_valid      = 1'b0;
        restart       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_RANK;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        in_writes = 1'b0;
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                if (!in_writes)
                begin
                    drain_results();
                    in_writes = 1'b1;
                end
                write_reg(script[i].regsel, script[i].value);
            end
            else
            begin
                if (in_writes)
                begin
                    cfg_we    <= 1'b0;
                    in_writes = 1'b0;
                end
                send_tick(script[i].rs, script[i].typed, script[i].want);
            end
        end

        // Largest sizes, reversed axes: strides up to 2^24
        drain_results();
        write_reg(REG_RANK, 9'd4);
        write_reg(REG_DIM0, 9'd256);
        write_reg(REG_DIM1, 9'd256);
        write_reg(REG_DIM2, 9'd256);
        write_reg(REG_DIM3, 9'd256);
        write_reg(REG_PERM, 9'd27);
        cfg_we <= 1'b0;
        repeat (40) send_tick(1'b0, 1'b0, blank);

        // One full 256-element walk and its wrap
        drain_results();
        write_reg(REG_RANK, 9'd1);
        write_reg(REG_DIM0, 9'd256);
        write_reg(REG_PERM, 9'd0);
        cfg_we <= 1'b0;
        repeat (258) send_tick(1'b0, 1'b0, blank);

        // Random settings, each followed by a stream of ticks
        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            drain_results();
            random_setting();
            walk = walk_length();
            if (walk <= 40)
            begin
                n = int'(walk) + $urandom_range(0, int'(walk) + 4);
            end
            else
            begin
                n = $urandom_range(12, 40);
            end
            repeat (n) send_tick(($urandom_range(0, 24) == 0), 1'b0, blank);
            random_beats += n;
        end

        drain_results();
        repeat (3) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: tensor_transpose_address_gen.f
rtl/core/tta_pkg.sv
rtl/core/tta_cell.sv
rtl/core/tta_derive.sv
rtl/core/tensor_transpose_address_gen.sv
bench/tensor_transpose_address_gen_tb.sv
